// ===== hw/rtl/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

    // Most bytes a single input item can produce (short unicode flush).
    localparam int MaxOut = 4;

    // Default depth of the queue between the front and the back.
    localparam int QueueDepth = 4;

    localparam int OutCntW = $clog2(MaxOut + 1);
    localparam int OutIdxW = $clog2(MaxOut);

    // All bytes produced by one input item, handed from front to back.
    typedef struct packed {
        logic [MaxOut-1:0][7:0] data;
        logic [OutCntW-1:0]     cnt;
        logic                   fin;
    } t_bundle;

endpackage

`default_nettype wire

// ===== hw/rtl/json_string_unescape_core.sv =====
// Channel | Valid       | Stall        | Payload
// input   | i_in_valid  | o_in_stall   | i_data_byte, i_end_of_string
// output  | o_out_valid | i_out_stall  | o_out_byte, o_last_of_run, o_string_done
//
// The front decodes one input beat per cycle while the queue has room.
// The back sends one output byte per cycle while i_out_stall is low, so an item
// that yields n bytes holds the back until its last byte leaves; a short unicode
// flush yields up to four. A byte passes a queue slot and r_cur to reach the output.
// Reset clears the decoder state, the queue pointers and the output valid.
// Output stalls fill the queue, which then raises o_in_stall.
`default_nettype none

module json_string_unescape_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::QueueDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_string,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_string_done
);

    jsu_pkg::t_bundle fr_bundle;
    jsu_pkg::t_bundle q_bundle;
    logic             push;
    logic             pop;
    logic             q_nonempty;
    logic             q_full;
    logic             in_accept;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    jsu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_bundle        (fr_bundle),
        .o_push          (push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_bundle   (fr_bundle),
        .i_pop      (pop),
        .o_bundle   (q_bundle),
        .o_nonempty (q_nonempty),
        .o_full     (q_full)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bundle      (q_bundle),
        .i_q_nonempty  (q_nonempty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_string_done (o_string_done)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
`default_nettype none

module jsu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_end_of_string,
    output jsu_pkg::t_bundle     o_bundle,
    output logic                 o_push
);

    typedef enum logic [2:0] {
        ModePlain = 3'b001,
        ModeEsc   = 3'b010,
        ModeHex   = 3'b100
    } t_mode;

    localparam logic [7:0]  ChBsl     = 8'h5C;
    localparam logic [7:0]  ChU       = 8'h75;
    localparam logic [15:0] Utf8Lim1  = 16'h0080;
    localparam logic [15:0] Utf8Lim2  = 16'h0800;
    localparam logic [7:0]  Lead2     = 8'hC0;
    localparam logic [7:0]  Lead3     = 8'hE0;
    localparam logic [7:0]  ContMark  = 8'h80;
    localparam logic [7:0]  ContMask  = 8'h3F;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [11:0] r_cp, n_cp;
    logic [1:0][7:0] r_held;

    // Bit 8 flags a recognized single-character escape, bits 7:0 its value.
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        logic [8:0] res;
        unique case (c)
            8'h22:   res = {1'b1, 8'h22};
            8'h5C:   res = {1'b1, 8'h5C};
            8'h2F:   res = {1'b1, 8'h2F};
            8'h62:   res = {1'b1, 8'h08};
            8'h66:   res = {1'b1, 8'h0C};
            8'h6E:   res = {1'b1, 8'h0A};
            8'h72:   res = {1'b1, 8'h0D};
            8'h74:   res = {1'b1, 8'h09};
            default: res = {1'b0, c};
        endcase
        return res;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else begin
            v = 4'h0;
        end
        return v;
    endfunction

    logic [7:0]  c;
    logic        fin;
    logic [8:0]  esc;
    logic [15:0] cp_full;
    logic [2:0][7:0] tbuf;
    logic [2:0][7:0] tnxt;
    logic [1:0]  tlen;
    logic        skip;
    logic [8:0]  tesc;
    logic [jsu_pkg::MaxOut-1:0][7:0] ob;
    logic [jsu_pkg::OutCntW-1:0]     on;

    assign c       = i_data_byte;
    assign fin     = i_end_of_string;
    assign esc     = simple_esc(c);
    assign cp_full = {r_cp, hex_val(c)};

    // Bytes gathered so far plus the current one, for the short-escape flush.
    assign tbuf[0] = (r_hex_cnt == 2'd0) ? c : r_held[0];
    assign tbuf[1] = (r_hex_cnt == 2'd1) ? c : r_held[1];
    assign tbuf[2] = c;
    assign tnxt[0] = tbuf[1];
    assign tnxt[1] = tbuf[2];
    assign tnxt[2] = tbuf[2];
    assign tlen    = r_hex_cnt + 2'd1;

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_cp      = r_cp;
        ob        = '0;
        on        = '0;
        skip      = 1'b0;
        tesc      = '0;
        unique case (r_mode)
            ModeEsc: begin
                n_mode = ModePlain;
                if (esc[8]) begin
                    ob[0] = esc[7:0];
                    on    = 3'd1;
                end else if (c == ChU) begin
                    if (fin) begin
                        ob[0] = ChU;
                        on    = 3'd1;
                    end else begin
                        n_mode    = ModeHex;
                        n_hex_cnt = 2'd0;
                        n_cp      = '0;
                    end
                end else begin
                    ob[0] = ChBsl;
                    ob[1] = c;
                    on    = 3'd2;
                end
            end
            ModeHex: begin
                n_cp = cp_full[11:0];
                if (r_hex_cnt == 2'd3) begin
                    n_mode    = ModePlain;
                    n_hex_cnt = 2'd0;
                    n_cp      = '0;
                    if (cp_full < Utf8Lim1) begin
                        ob[0] = cp_full[7:0];
                        on    = 3'd1;
                    end else if (cp_full < Utf8Lim2) begin
                        ob[0] = Lead2 | {3'b000, cp_full[10:6]};
                        ob[1] = ContMark | (cp_full[7:0] & ContMask);
                        on    = 3'd2;
                    end else begin
                        ob[0] = Lead3 | {4'h0, cp_full[15:12]};
                        ob[1] = ContMark | (cp_full[13:6] & ContMask);
                        ob[2] = ContMark | (cp_full[7:0] & ContMask);
                        on    = 3'd3;
                    end
                end else if (fin) begin
                    // The string ended inside the escape: drop the backslash
                    // and decode the gathered bytes as a short final string.
                    n_mode    = ModePlain;
                    n_hex_cnt = 2'd0;
                    n_cp      = '0;
                    ob[0]     = ChU;
                    on        = 3'd1;
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < tlen && !skip) begin
                            tesc = simple_esc(tnxt[k]);
                            if (tbuf[k] == ChBsl && 2'(k + 1) < tlen) begin
                                if (tesc[8]) begin
                                    ob[on[jsu_pkg::OutIdxW-1:0]] = tesc[7:0];
                                    on   = on + 3'd1;
                                    skip = 1'b1;
                                end else if (tnxt[k] != ChU) begin
                                    ob[on[jsu_pkg::OutIdxW-1:0]] = ChBsl;
                                    on = on + 3'd1;
                                end
                            end else begin
                                ob[on[jsu_pkg::OutIdxW-1:0]] = tbuf[k];
                                on = on + 3'd1;
                            end
                        end else begin
                            skip = 1'b0;
                        end
                    end
                end else begin
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end
            end
            default: begin
                if (c == ChBsl && !fin) begin
                    n_mode = ModeEsc;
                end else begin
                    n_mode = ModePlain;
                    ob[0]  = c;
                    on     = 3'd1;
                end
            end
        endcase
        if (fin) begin
            n_mode    = ModePlain;
            n_hex_cnt = 2'd0;
            n_cp      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ModePlain;
            r_hex_cnt <= 2'd0;
            r_cp      <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_cp      <= n_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_mode == ModeHex && !fin && r_hex_cnt < 2'd2) begin
            r_held[r_hex_cnt[0]] <= c;
        end
    end

    assign o_bundle.data = ob;
    assign o_bundle.cnt  = on;
    assign o_bundle.fin  = fin;
    assign o_push        = i_accept && (on != '0);

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_queue.sv =====
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QueueDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire jsu_pkg::t_bundle  i_bundle,
    input  wire logic              i_pop,
    output jsu_pkg::t_bundle       o_bundle,
    output logic                   o_nonempty,
    output logic                   o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_bundle r_slot [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_bundle;
        end
    end

    assign o_bundle   = r_slot[r_rd];
    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == CW'(DEPTH));

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
`default_nettype none

module jsu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire jsu_pkg::t_bundle i_bundle,
    input  wire logic            i_q_nonempty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_of_run,
    output logic                 o_string_done
);

    jsu_pkg::t_bundle                r_cur;
    logic [jsu_pkg::OutIdxW-1:0]     r_idx;
    logic                            r_have;
    logic                            last;
    logic                            beat;

    assign last  = ({1'b0, r_idx} == r_cur.cnt - 1'b1);
    assign beat  = r_have && !i_out_stall;
    // Take the next bundle when idle or when the final byte of this one leaves.
    assign o_pop = i_q_nonempty && (!r_have || (beat && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx  <= '0;
        end else if (beat) begin
            if (last) begin
                r_have <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_bundle;
        end
    end

    assign o_out_valid   = r_have;
    assign o_out_byte    = r_cur.data[r_idx];
    assign o_last_of_run = last;
    assign o_string_done = last && r_cur.fin;

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_checker.sv =====
`default_nettype none

module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_data_byte,
    input wire logic       i_end_of_string,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last_of_run,
    input wire logic       o_string_done
);

    // A pending output beat is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_out_byte) && $stable(o_last_of_run) && $stable(o_string_done))
        else $error("output payload changed while stalled");

    // The end of a string is always the end of a run.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_done |-> o_last_of_run)
        else $error("string done without last of run");

    // Reset leaves both channels empty and ready.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channels not idle after reset");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (.*);

`default_nettype wire
